>>> rtl/slr_pkg.sv
`timescale 1ns / 1ps

package slr_pkg;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_OUT = 1'b1;

    localparam logic [CFG_W-1:0] FRAMES_IN_RST  = 13'd441;
    localparam logic [CFG_W-1:0] FRAMES_OUT_RST = 13'd480;

    localparam int RUN_LIMIT = 64;
    localparam int RUN_W     = $clog2(RUN_LIMIT + 1);

    typedef enum logic [3:0] {
        CTL_IDLE,
        CTL_MUL,
        CTL_IDX,
        CTL_IDX_WAIT,
        CTL_TEST,
        CTL_NEXT,
        CTL_WORK,
        CTL_EMIT,
        CTL_FINISH
    } t_ctl_state;

    typedef enum logic [1:0] {
        LANE_IDLE,
        LANE_SUM,
        LANE_DIV_START,
        LANE_DIV
    } t_lane_state;

endpackage

>>> rtl/slr_frame_if.sv
`timescale 1ns / 1ps

interface slr_frame_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] in_ch0;
    logic signed [SAMPLE_BITS-1:0] in_ch1;

    modport source (output valid, output in_ch0, output in_ch1, input ready);
    modport sink (input valid, input in_ch0, input in_ch1, output ready);
endinterface

>>> rtl/slr_result_if.sv
`timescale 1ns / 1ps

interface slr_result_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_ch0;
    logic signed [SAMPLE_BITS-1:0] out_ch1;
    logic                          last_of_run;

    modport source (output valid, output out_ch0, output out_ch1, output last_of_run,
                    input ready);
    modport sink (input valid, input out_ch0, input out_ch1, input last_of_run,
                  output ready);
endinterface

>>> rtl/slr_div.sv
`timescale 1ns / 1ps

module slr_div
    import slr_pkg::*;
#(
    parameter int N_W = 26,
    parameter int D_W = 13
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic           o_done,
    output logic [N_W-1:0] o_quo,
    output logic [D_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   r_quo, n_quo;
    logic [D_W-1:0]   r_rem, n_rem;
    logic [D_W-1:0]   r_den;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_done, n_done;
    logic [D_W:0]     trial;
    logic             fits;

    always_comb begin
        trial  = {r_rem, r_quo[N_W-1]};
        fits   = (trial >= {1'b0, r_den});
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_quo = i_num;
            n_rem = '0;
            n_cnt = CNT_W'(N_W);
        end else if (r_cnt != '0) begin
            n_quo  = {r_quo[N_W-2:0], fits};
            n_rem  = fits ? D_W'(trial - {1'b0, r_den}) : trial[D_W-1:0];
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

>>> rtl/slr_lane.sv
`timescale 1ns / 1ps

module slr_lane
    import slr_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int CNT_W       = 13
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [SAMPLE_BITS-1:0] i_prev,
    input  logic signed [SAMPLE_BITS-1:0] i_cur,
    input  logic        [CNT_W-1:0]       i_w,
    input  logic        [CNT_W-1:0]       i_r,
    input  logic        [CNT_W-1:0]       i_fo,
    output logic                          o_done,
    output logic signed [SAMPLE_BITS-1:0] o_res
);

    localparam int PROD_W = SAMPLE_BITS + CNT_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int MAG_W  = SAMPLE_BITS + CNT_W;

    t_lane_state r_state, n_state;

    logic signed [PROD_W-1:0]      r_prod_a, r_prod_b;
    logic signed [SUM_W-1:0]       r_num;
    logic signed [SUM_W-1:0]       num_abs;
    logic        [CNT_W-1:0]       r_fo;
    logic                          r_neg;
    logic        [SAMPLE_BITS-1:0] r_res;
    logic        [SAMPLE_BITS-1:0] q_mag;
    logic                          r_done, n_done;
    logic                          div_start;
    logic                          div_done;
    logic        [MAG_W-1:0]       div_quo;
    logic        [CNT_W-1:0]       div_rem;
    logic                          unused_div_rem;

    always_comb begin
        n_state   = r_state;
        n_done    = 1'b0;
        div_start = 1'b0;
        unique case (r_state)
            LANE_IDLE: begin
                if (i_start) begin
                    n_state = LANE_SUM;
                end
            end
            LANE_SUM: begin
                n_state = LANE_DIV_START;
            end
            LANE_DIV_START: begin
                div_start = 1'b1;
                n_state   = LANE_DIV;
            end
            LANE_DIV: begin
                if (div_done) begin
                    n_done  = 1'b1;
                    n_state = LANE_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LANE_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign num_abs = r_num[SUM_W-1] ? -r_num : r_num;
    assign q_mag   = div_quo[SAMPLE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (i_start && (r_state == LANE_IDLE)) begin
            r_prod_a <= PROD_W'(i_prev) * PROD_W'($signed({1'b0, i_w}));
            r_prod_b <= PROD_W'(i_cur) * PROD_W'($signed({1'b0, i_r}));
            r_fo     <= i_fo;
        end
        if (r_state == LANE_SUM) begin
            r_num <= SUM_W'(r_prod_a) + SUM_W'(r_prod_b);
        end
        if (r_state == LANE_DIV_START) begin
            r_neg <= r_num[SUM_W-1];
        end
        if (div_done) begin
            r_res <= r_neg ? (~q_mag + 1'b1) : q_mag;
        end
    end

    slr_div #(
        .N_W (MAG_W),
        .D_W (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_abs[MAG_W-1:0]),
        .i_den   (r_fo),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    assign unused_div_rem = ^div_rem;

    assign o_done = r_done;
    assign o_res  = $signed(r_res);

endmodule

>>> rtl/stereo_linear_resampler.sv
`timescale 1ns / 1ps

// Stereo linear resampler. Input words carry one stereo frame (in_ch0, in_ch1)
// on the i_frame channel; output words carry one interpolated frame and a
// last_of_run flag on the o_result channel. Both channels use valid/ready.
// Block sizes frames_in and frames_out are set through the write port
// (index 0 and 1); the user must write them only while no frame is in
// flight, as the block itself does not enforce it; zero acts as one.
// One frame is processed at a time and i_frame.ready is high only when idle.
// A frame first divides its output position by frames_out in a bit-serial
// divider with a 2*CNT_W-bit numerator. Each output then runs both channel
// lanes, each a multiply, an add and a bit-serial divide of a
// SAMPLE_BITS+CNT_W-bit magnitude, while the position of the next output is
// divided in parallel. A frame with no output due returns the block to idle.
// At most 64 outputs follow one frame, the last one flagged. A stalled
// receiver holds the output register and the block waits for it without
// losing a word. Reset restores 441 and 480, clears the previous frame to
// zero and restarts the block.

module stereo_linear_resampler
    import slr_pkg::*;
#(
    parameter int MAX_BLOCK_FRAMES = 4096,
    parameter int SAMPLE_BITS      = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    slr_frame_if.sink            i_frame,
    slr_result_if.source         o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int CNT_W = ($clog2(MAX_BLOCK_FRAMES + 1) < CFG_W) ?
                           $clog2(MAX_BLOCK_FRAMES + 1) : CFG_W;
    localparam int P_W   = 2 * CNT_W;

    function automatic logic [CNT_W-1:0] eff_count(input logic [CFG_W-1:0] v);
        logic [CNT_W-1:0] res;
        if (v == '0) begin
            res = CNT_W'(1);
        end else if (32'(v) > 32'(MAX_BLOCK_FRAMES)) begin
            res = CNT_W'(MAX_BLOCK_FRAMES);
        end else begin
            res = v[CNT_W-1:0];
        end
        return res;
    endfunction

    t_ctl_state r_state, n_state;

    logic [CFG_W-1:0]              r_frames_in, r_frames_out;
    logic [CNT_W-1:0]              fi, fo;
    logic signed [SAMPLE_BITS-1:0] r_cur0, r_cur1, r_prev0, r_prev1;
    logic [CNT_W-1:0]              r_frame_idx, r_out_idx;
    logic [RUN_W-1:0]              r_run;
    logic [P_W-1:0]                r_p;
    logic [P_W-1:0]                r_k;
    logic [CNT_W-1:0]              r_r;
    logic                          r_lane_done, r_idx_done;
    logic                          r_out_valid, r_out_last;
    logic signed [SAMPLE_BITS-1:0] r_out_ch0, r_out_ch1;

    logic                          frame_ready;
    logic                          accept;
    logic                          idx_start, lane_start, load;
    logic                          due, next_due;
    logic                          out_free;
    logic [CNT_W-1:0]              mul_idx;
    logic [CNT_W-1:0]              lane_w;
    logic [CNT_W:0]                out_idx_inc, frame_idx_inc;
    logic                          idx_done;
    logic [P_W-1:0]                idx_quo;
    logic [CNT_W-1:0]              idx_rem;
    logic                          lane0_done, lane1_done;
    logic signed [SAMPLE_BITS-1:0] lane0_res, lane1_res;

    assign fi = eff_count(r_frames_in);
    assign fo = eff_count(r_frames_out);

    assign out_idx_inc   = {1'b0, r_out_idx} + 1'b1;
    assign frame_idx_inc = {1'b0, r_frame_idx} + 1'b1;
    assign lane_w        = fo - r_r;
    assign mul_idx       = (r_state == CTL_TEST) ? out_idx_inc[CNT_W-1:0] : r_out_idx;
    assign out_free      = !r_out_valid || o_result.ready;
    assign accept        = frame_ready && i_frame.valid;

    assign due      = (r_run < RUN_W'(RUN_LIMIT)) && (r_out_idx < fo) &&
                      (r_k <= P_W'(r_frame_idx));
    assign next_due = ((r_run + 1'b1) < RUN_W'(RUN_LIMIT)) &&
                      (out_idx_inc < {1'b0, fo}) && (r_k <= P_W'(r_frame_idx));

    always_comb begin
        n_state     = r_state;
        frame_ready = 1'b0;
        idx_start   = 1'b0;
        lane_start  = 1'b0;
        load        = 1'b0;
        unique case (r_state)
            CTL_IDLE: begin
                frame_ready = 1'b1;
                if (i_frame.valid) begin
                    n_state = CTL_MUL;
                end
            end
            CTL_MUL: begin
                n_state = CTL_IDX;
            end
            CTL_IDX: begin
                idx_start = 1'b1;
                n_state   = CTL_IDX_WAIT;
            end
            CTL_IDX_WAIT: begin
                if (idx_done) begin
                    n_state = CTL_TEST;
                end
            end
            CTL_TEST: begin
                if (due) begin
                    lane_start = 1'b1;
                    n_state    = CTL_NEXT;
                end else begin
                    n_state = CTL_FINISH;
                end
            end
            CTL_NEXT: begin
                idx_start = 1'b1;
                n_state   = CTL_WORK;
            end
            CTL_WORK: begin
                if (r_lane_done && r_idx_done) begin
                    n_state = CTL_EMIT;
                end
            end
            CTL_EMIT: begin
                if (out_free) begin
                    load    = 1'b1;
                    n_state = CTL_TEST;
                end
            end
            CTL_FINISH: begin
                n_state = CTL_IDLE;
            end
            default: begin
                n_state = CTL_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= CTL_IDLE;
            r_frames_in  <= FRAMES_IN_RST;
            r_frames_out <= FRAMES_OUT_RST;
            r_prev0      <= '0;
            r_prev1      <= '0;
            r_frame_idx  <= '0;
            r_out_idx    <= '0;
            r_run        <= '0;
            r_lane_done  <= 1'b0;
            r_idx_done   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_FRAMES_IN) begin
                    r_frames_in <= i_cfg_data;
                end else begin
                    r_frames_out <= i_cfg_data;
                end
            end
            if (accept) begin
                r_run <= '0;
            end else if (load) begin
                r_run     <= r_run + 1'b1;
                r_out_idx <= out_idx_inc[CNT_W-1:0];
            end else if (r_state == CTL_FINISH) begin
                r_prev0 <= r_cur0;
                r_prev1 <= r_cur1;
                if (frame_idx_inc >= {1'b0, fi}) begin
                    r_frame_idx <= '0;
                    r_out_idx   <= '0;
                end else begin
                    r_frame_idx <= frame_idx_inc[CNT_W-1:0];
                end
            end
            if (lane_start) begin
                r_lane_done <= 1'b0;
                r_idx_done  <= 1'b0;
            end else begin
                if (lane0_done) begin
                    r_lane_done <= 1'b1;
                end
                if (idx_done) begin
                    r_idx_done <= 1'b1;
                end
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cur0 <= i_frame.in_ch0;
            r_cur1 <= i_frame.in_ch1;
        end
        if ((r_state == CTL_MUL) || (r_state == CTL_TEST)) begin
            r_p <= P_W'(mul_idx) * P_W'(fi);
        end
        if (idx_done) begin
            r_k <= idx_quo;
            r_r <= idx_rem;
        end
        if (load) begin
            r_out_ch0  <= lane0_res;
            r_out_ch1  <= lane1_res;
            r_out_last <= !next_due;
        end
    end

    slr_div #(
        .N_W (P_W),
        .D_W (CNT_W)
    ) u_index_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (idx_start),
        .i_num   (r_p),
        .i_den   (fo),
        .o_done  (idx_done),
        .o_quo   (idx_quo),
        .o_rem   (idx_rem)
    );

    slr_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .CNT_W       (CNT_W)
    ) u_lane0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (lane_start),
        .i_prev  (r_prev0),
        .i_cur   (r_cur0),
        .i_w     (lane_w),
        .i_r     (r_r),
        .i_fo    (fo),
        .o_done  (lane0_done),
        .o_res   (lane0_res)
    );

    slr_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .CNT_W       (CNT_W)
    ) u_lane1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (lane_start),
        .i_prev  (r_prev1),
        .i_cur   (r_cur1),
        .i_w     (lane_w),
        .i_r     (r_r),
        .i_fo    (fo),
        .o_done  (lane1_done),
        .o_res   (lane1_res)
    );

    // Both lanes run in lockstep; the second one's done pulse is redundant.
    logic unused_lane1_done;
    assign unused_lane1_done = lane1_done;

    assign i_frame.ready        = frame_ready;
    assign o_result.valid       = r_out_valid;
    assign o_result.out_ch0     = r_out_ch0;
    assign o_result.out_ch1     = r_out_ch1;
    assign o_result.last_of_run = r_out_last;

endmodule
